FILE: rtl/core/icmprw_pkg.sv
package icmprw_pkg;

  // Frame layout: Ethernet header then a fixed 20-byte IPv4 header.
  localparam logic [5:0] HDR_LEN    = 6'd34;
  localparam logic [5:0] LAST_POS   = 6'd33;
  localparam logic [5:0] MAC_SRC    = 6'd6;
  localparam logic [5:0] ETH_LEN    = 6'd14;
  localparam logic [5:0] PROTO_POS  = 6'd23;
  localparam logic [5:0] CSUM_HI    = 6'd24;
  localparam logic [5:0] CSUM_LO    = 6'd25;
  localparam logic [5:0] SRC_IP_POS = 6'd26;
  localparam logic [5:0] DST_IP_POS = 6'd30;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  // Configuration register indexes.
  localparam logic [2:0] REG_OWN_MAC      = 3'd0;
  localparam logic [2:0] REG_NEXT_HOP_MAC = 3'd1;
  localparam logic [2:0] REG_OWN_IP       = 3'd2;
  localparam logic [2:0] REG_PEER_A_IP    = 3'd3;
  localparam logic [2:0] REG_PEER_C_IP    = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_frame_end;
  } out_item_t;

  // Header buffer write and read ports.
  typedef struct packed {
    logic       en;
    logic [5:0] addr;
    logic [7:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic       en;
    logic [5:0] addr;
  } mem_rd_t;

  // Byte of a MAC address in wire order, first byte most significant.
  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] sel);
    logic [7:0] res;
    case (sel)
      3'd0: res = mac[47:40];
      3'd1: res = mac[39:32];
      3'd2: res = mac[31:24];
      3'd3: res = mac[23:16];
      3'd4: res = mac[15:8];
      3'd5: res = mac[7:0];
      default: res = 8'h00;
    endcase
    return res;
  endfunction

  // Byte of an IPv4 address in wire order.
  function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] sel);
    logic [7:0] res;
    case (sel)
      2'd0: res = ip[31:24];
      2'd1: res = ip[23:16];
      2'd2: res = ip[15:8];
      2'd3: res = ip[7:0];
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/core/icmprw_hdr_store.sv
module icmprw_hdr_store (
  input  logic               clk,
  input  icmprw_pkg::mem_wr_t wr,
  input  icmprw_pkg::mem_rd_t rd,
  output logic [7:0]         rd_data
);

  // One entry per header byte; read data is registered and held when idle.
  logic [7:0] mem [0:33];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

FILE: rtl/core/icmprw_csum.sv
module icmprw_csum (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [18:0] partial,
  input  logic [31:0] src_ip,
  input  logic [31:0] dst_ip,
  output logic [15:0] csum,
  output logic        busy
);

  logic [19:0] acc;
  logic [1:0]  step;

  // Four steps: add source halves, add destination halves, then two end-around folds.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 2'd1;
    end else if (busy) begin
      step <= step + 2'd1;
      if (step == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= {1'b0, partial} + {4'b0, src_ip[31:16]} + {4'b0, src_ip[15:0]};
    end else if (busy) begin
      case (step)
        2'd1: acc <= acc + {4'b0, dst_ip[31:16]} + {4'b0, dst_ip[15:0]};
        default: acc <= {4'b0, acc[15:0]} + {16'b0, acc[19:16]};
      endcase
    end
  end

  assign csum = ~acc[15:0];

endmodule

FILE: rtl/core/icmp_relay_header_rewriter_unit.sv
// ICMP relay header rewriter.
// Frame bytes enter on the in channel (valid/ready), one byte per request, with
// in_frame_end on the last byte. The first 34 bytes are written to a header buffer
// while the MAC, protocol and address fields are checked and the checksum partial
// sum is gathered on the fly. On byte 34 the frame is forwarded or dropped.
// A forwarded header is read back from the buffer and emitted as 34 rewritten
// bytes at one byte per cycle, the first one passing the buffer read register
// and the output register after byte 34 is taken; input is held off during that
// burst. Later bytes of a forwarded frame pass through the output register at
// one per cycle. Header bytes and dropped frames are taken at one per cycle and
// give no output. The output register holds a single byte; when the receiver
// stalls, the header burst pauses and pass-through input is held off.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while the block is idle, as the block itself does not
// enforce this. Synchronous reset clears the configuration, the exchange state
// and all control; the header buffer needs no clearing.
module icmp_relay_header_rewriter_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  icmprw_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output icmprw_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [47:0]           cfg_data
);

  localparam logic [1:0] MODE_COLLECT = 2'd0;
  localparam logic [1:0] MODE_PASS    = 2'd1;
  localparam logic [1:0] MODE_DROP    = 2'd2;
  localparam logic [1:0] MODE_EMIT    = 2'd3;

  logic [47:0] own_mac, next_hop_mac;
  logic [31:0] own_ip, peer_a_ip, peer_c_ip;

  logic [1:0]  mode;
  logic [5:0]  pos;
  logic        mac_ok, proto_ok;
  logic [7:0]  word_hi;
  logic [18:0] psum;
  logic [31:0] src_ip;
  logic [23:0] dst_hi;
  logic        pending;
  logic [31:0] saved_ip;
  logic [31:0] new_src, new_dst;
  logic        end_flag;
  logic        csum_start;
  logic [15:0] csum;
  logic        csum_busy;

  logic [5:0]  idx;
  logic        rd_valid;
  logic [5:0]  rd_pos;
  logic [7:0]  rd_data;

  logic        in_acc, collect_acc, last_hdr;
  logic        from_a, from_c, fwd;
  logic        hdr_load, fetch_en, pass_load;
  logic [7:0]  b;
  logic [5:0]  off_mac, off_src, off_dst;
  logic [7:0]  hdr_byte;

  icmprw_pkg::mem_wr_t mem_wr;
  icmprw_pkg::mem_rd_t mem_rd;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac      <= '0;
      next_hop_mac <= '0;
      own_ip       <= '0;
      peer_a_ip    <= '0;
      peer_c_ip    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        icmprw_pkg::REG_OWN_MAC:      own_mac      <= cfg_data;
        icmprw_pkg::REG_NEXT_HOP_MAC: next_hop_mac <= cfg_data;
        icmprw_pkg::REG_OWN_IP:       own_ip       <= cfg_data[31:0];
        icmprw_pkg::REG_PEER_A_IP:    peer_a_ip    <= cfg_data[31:0];
        icmprw_pkg::REG_PEER_C_IP:    peer_c_ip    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Input handshake and forwarding decision on the last header byte.
  always_comb begin
    case (mode)
      MODE_COLLECT: in_ready = 1'b1;
      MODE_DROP:    in_ready = 1'b1;
      MODE_PASS:    in_ready = !out_valid || out_ready;
      default:      in_ready = 1'b0;
    endcase
  end

  assign b           = in_data.in_byte;
  assign in_acc      = in_valid && in_ready;
  assign collect_acc = in_acc && (mode == MODE_COLLECT);
  assign last_hdr    = collect_acc && (pos == icmprw_pkg::LAST_POS);
  assign from_a      = mac_ok && proto_ok && (src_ip == peer_a_ip);
  assign from_c      = mac_ok && proto_ok && !from_a && (src_ip == peer_c_ip) && pending;
  assign fwd         = from_a || from_c;

  assign mem_wr.en   = collect_acc;
  assign mem_wr.addr = pos;
  assign mem_wr.data = b;

  // Header collection: field checks and partial checksum of the fixed IP words.
  always_ff @(posedge clk) begin
    if (collect_acc) begin
      if (pos == 6'd0) begin
        mac_ok <= (b == icmprw_pkg::mac_byte(own_mac, pos[2:0]));
        psum   <= '0;
      end else if (pos < icmprw_pkg::MAC_SRC) begin
        mac_ok <= mac_ok && (b == icmprw_pkg::mac_byte(own_mac, pos[2:0]));
      end
      if (pos == icmprw_pkg::PROTO_POS) begin
        proto_ok <= (b == icmprw_pkg::PROTO_ICMP);
      end
      if (pos >= icmprw_pkg::ETH_LEN && pos <= icmprw_pkg::PROTO_POS) begin
        if (!pos[0]) begin
          word_hi <= b;
        end else begin
          psum <= psum + {3'b0, word_hi, b};
        end
      end
      if (pos >= icmprw_pkg::SRC_IP_POS && pos < icmprw_pkg::DST_IP_POS) begin
        src_ip <= {src_ip[23:0], b};
      end
      if (pos >= icmprw_pkg::DST_IP_POS && pos < icmprw_pkg::LAST_POS) begin
        dst_hi <= {dst_hi[15:0], b};
      end
    end
    if (last_hdr) begin
      end_flag <= in_data.in_frame_end;
      if (from_a) begin
        new_src <= own_ip;
        new_dst <= peer_c_ip;
      end else begin
        new_src <= saved_ip;
        new_dst <= peer_a_ip;
      end
    end
  end

  // Exchange state kept across frames.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= 1'b0;
      saved_ip <= '0;
    end else if (last_hdr) begin
      if (from_a && !pending) begin
        pending  <= 1'b1;
        saved_ip <= {dst_hi, b};
      end else if (from_c) begin
        pending <= 1'b0;
      end
    end
  end

  // Header read-back pipeline: buffer read register, then the output register.
  assign hdr_load  = rd_valid && (!out_valid || out_ready);
  assign fetch_en  = (mode == MODE_EMIT) && (idx != icmprw_pkg::HDR_LEN)
                     && (!rd_valid || hdr_load);
  assign pass_load = in_acc && (mode == MODE_PASS);

  assign mem_rd.en   = fetch_en;
  assign mem_rd.addr = idx;

  // Frame mode, byte position and read pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_COLLECT;
      pos        <= '0;
      idx        <= '0;
      rd_valid   <= 1'b0;
      csum_start <= 1'b0;
    end else begin
      csum_start <= last_hdr && fwd;
      if (fetch_en) begin
        rd_valid <= 1'b1;
        rd_pos   <= idx;
        idx      <= idx + 6'd1;
      end else if (hdr_load) begin
        rd_valid <= 1'b0;
      end
      case (mode)
        MODE_COLLECT: begin
          if (collect_acc) begin
            if (last_hdr || in_data.in_frame_end) begin
              pos <= '0;
            end else begin
              pos <= pos + 6'd1;
            end
            if (last_hdr) begin
              if (fwd) begin
                mode <= MODE_EMIT;
                idx  <= '0;
              end else if (!in_data.in_frame_end) begin
                mode <= MODE_DROP;
              end
            end
          end
        end
        MODE_EMIT: begin
          if (idx == icmprw_pkg::HDR_LEN && !rd_valid) begin
            mode <= end_flag ? MODE_COLLECT : MODE_PASS;
          end
        end
        default: begin
          if (in_acc && in_data.in_frame_end) begin
            mode <= MODE_COLLECT;
          end
        end
      endcase
    end
  end

  // Rewritten header byte for the position held in the read register.
  assign off_mac = rd_pos - icmprw_pkg::MAC_SRC;
  assign off_src = rd_pos - icmprw_pkg::SRC_IP_POS;
  assign off_dst = rd_pos - icmprw_pkg::DST_IP_POS;

  always_comb begin
    if (rd_pos < icmprw_pkg::MAC_SRC) begin
      hdr_byte = icmprw_pkg::mac_byte(next_hop_mac, rd_pos[2:0]);
    end else if (rd_pos < icmprw_pkg::ETH_LEN - 6'd2) begin
      hdr_byte = icmprw_pkg::mac_byte(own_mac, off_mac[2:0]);
    end else if (rd_pos == icmprw_pkg::CSUM_HI) begin
      hdr_byte = csum[15:8];
    end else if (rd_pos == icmprw_pkg::CSUM_LO) begin
      hdr_byte = csum[7:0];
    end else if (rd_pos >= icmprw_pkg::DST_IP_POS) begin
      hdr_byte = icmprw_pkg::ip_byte(new_dst, off_dst[1:0]);
    end else if (rd_pos >= icmprw_pkg::SRC_IP_POS) begin
      hdr_byte = icmprw_pkg::ip_byte(new_src, off_src[1:0]);
    end else begin
      hdr_byte = rd_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hdr_load || pass_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_load) begin
      out_data.out_byte      <= hdr_byte;
      out_data.out_frame_end <= end_flag && (rd_pos == icmprw_pkg::LAST_POS);
    end else if (pass_load) begin
      out_data.out_byte      <= b;
      out_data.out_frame_end <= in_data.in_frame_end;
    end
  end

  icmprw_hdr_store u_store (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (rd_data)
  );

  icmprw_csum u_csum (
    .clk     (clk),
    .rst     (rst),
    .start   (csum_start),
    .partial (psum),
    .src_ip  (new_src),
    .dst_ip  (new_dst),
    .csum    (csum),
    .busy    (csum_busy)
  );

  // The checksum must be settled before its first byte leaves the read register.
  a_csum_ready: assert property (@(posedge clk) disable iff (rst)
    hdr_load && (rd_pos == icmprw_pkg::CSUM_HI) |-> !csum_busy)
    else $error("checksum byte emitted while checksum still in progress");

  // The buffer is never written while a header is being read back.
  a_no_write_in_emit: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_EMIT) |-> !mem_wr.en)
    else $error("header buffer written during read-back");

  // Read data is only in flight during the header burst.
  a_rd_in_emit: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (mode == MODE_EMIT))
    else $error("header read pending outside header burst");

  // A forwarding decision always starts a header burst on the next cycle.
  a_emit_follows: assert property (@(posedge clk) disable iff (rst)
    last_hdr && fwd |=> (mode == MODE_EMIT) && (idx == 6'd0) && csum_start)
    else $error("forwarded header did not start read-back");

endmodule
